>>> rtl/core/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication on aclk, off while aresetn is low
`define GTMT_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication on aclk, off while aresetn is low
`define GTMT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/gtmt_pkg.sv
`default_nettype none

package gtmt_pkg;

    localparam int ENTRIES   = 1024;
    localparam int ADDR_W    = $clog2(ENTRIES);
    localparam int GEN_BITS  = 15;
    localparam int ART_BITS  = 32;
    localparam int SLOT_BITS = 16;
    localparam int WORD_W    = 64;

    localparam int ART_SHIFT = SLOT_BITS;
    localparam int GEN_SHIFT = SLOT_BITS + ART_BITS;
    localparam int BOUND_POS = WORD_W - 1;

    localparam logic [63:0] GEN_MAX  = (64'd1 << GEN_BITS) - 64'd1;
    localparam logic [63:0] ART_MAX  = (64'd1 << ART_BITS) - 64'd1;
    localparam logic [63:0] SLOT_MAX = (64'd1 << SLOT_BITS) - 64'd1;

    localparam int CFG_W = 11;
    localparam logic [CFG_W-1:0] TABLE_SIZE_RST = CFG_W'(1024);

    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_LOOKUP  = 3'd0;
    localparam logic [OP_W-1:0] OP_RESTORE = 3'd1;
    localparam logic [OP_W-1:0] OP_BIND    = 3'd2;
    localparam logic [OP_W-1:0] OP_RELEASE = 3'd3;
    localparam logic [OP_W-1:0] OP_REBIND  = 3'd4;

    typedef logic [WORD_W-1:0]    word_t;
    typedef logic [GEN_BITS-1:0]  gen_t;
    typedef logic [ART_BITS-1:0]  art_t;
    typedef logic [SLOT_BITS-1:0] slot_t;

    // input word, first field in the lowest bits
    typedef struct packed {
        logic [5:0]  pad;
        logic [15:0] new_slot;
        logic [31:0] new_artifact;
        logic [31:0] expect_gen;
        logic [15:0] expected_slot;
        logic [31:0] expected_artifact;
        logic        expected_bound;
        logic        expected_valid;
        logic [63:0] encoded_word;
        logic [31:0] source;
    } in_word_t;

    // result word, first field in the lowest bits
    typedef struct packed {
        logic [5:0]  pad;
        logic [63:0] entry_word;
        logic [14:0] entry_generation;
        logic [15:0] entry_slot;
        logic [31:0] entry_artifact;
        logic        entry_bound;
        logic        entry_valid;
        logic        success;
    } out_word_t;

    localparam int S_TDATA_W = $bits(in_word_t);
    localparam int M_TDATA_W = $bits(out_word_t);

    function automatic word_t word_unbound(gen_t g);
        word_t w;
        w = '0;
        w[GEN_SHIFT +: GEN_BITS] = g;
        return w;
    endfunction

    function automatic word_t word_bound(art_t a, slot_t s, gen_t g);
        word_t w;
        w = '0;
        w[BOUND_POS]             = 1'b1;
        w[GEN_SHIFT +: GEN_BITS] = g;
        w[ART_SHIFT +: ART_BITS] = a;
        w[SLOT_BITS-1:0]         = s;
        return w;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/gtmt_ram.sv
`default_nettype none

module gtmt_ram #(
    parameter int DEPTH  = 1024,
    parameter int WIDTH  = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/generation_tagged_mapping_table.sv
// Generation-tagged mapping table: 1024 entries of 64-bit words (bound flag at bit 63,
// generation in bits 62:48, artifact in 47:16, slot in 15:0), held in one single-port
// read, single-port write memory. Each word is one operation (tuser) on one entry:
// lookup, restore, bind, release or rebind, the last four done as a compare-and-swap.
// After reset the block sweeps the memory to zero, one entry per cycle, with s_tready
// low; table_size writes are taken during that time. An accepted word issues the read of
// its entry at the accepting edge; in the next cycle the entry is compared, and once the
// output register is free the entry is written back if the compare matched and the
// result register is loaded. The block takes no new word until the last one has left
// S_EXEC, as set by the read then write-back of the entry memory. The next word is
// accepted while a finished result still waits in the output register; a word whose
// result finds the output register still full waits until it drains.
`default_nettype none
`include "assert_macros.svh"

module generation_tagged_mapping_table (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [gtmt_pkg::CFG_W-1:0]        cfg_wr_data,   // table_size
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // source, encoded_word, expected_valid, expected_bound, expected_artifact,
    // expected_slot, expect_gen, new_artifact, new_slot, zero fill
    input  wire logic [gtmt_pkg::S_TDATA_W-1:0]    s_tdata,
    input  wire logic [gtmt_pkg::OP_W-1:0]         s_tuser,       // operation
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // success, entry_valid, entry_bound, entry_artifact, entry_slot,
    // entry_generation, entry_word, zero fill
    output logic      [gtmt_pkg::M_TDATA_W-1:0]    m_tdata
);

    import gtmt_pkg::*;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } state_t;

    state_t           state_reg;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic [CFG_W-1:0]  table_size_reg;
    logic              m_tvalid_reg;
    out_word_t         m_tdata_reg;

    logic [ADDR_W-1:0] addr_reg;
    logic              pre_ok_reg;
    logic              lookup_reg;
    word_t             expect_reg;
    word_t             desired_reg;

    logic              pre_ok_next;
    logic              lookup_next;
    word_t             expect_next;
    word_t             desired_next;

    in_word_t  in_w;
    out_word_t res;
    logic      s_accept;
    logic      out_free;
    logic      fire;
    logic      hit;
    logic      in_range;
    logic      gen_ok;
    logic      new_ok;
    logic      exp_ok;
    gen_t      gen_cur;
    gen_t      gen_inc;
    word_t     ew;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    word_t             ram_wdata;
    word_t             ram_rdata;

    assign in_w     = s_tdata;
    assign s_tready = (state_reg == S_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign fire     = (state_reg == S_EXEC) && out_free;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // checks that depend only on the incoming word and table_size
    assign ew       = in_w.encoded_word;
    assign gen_cur  = in_w.expect_gen[GEN_BITS-1:0];
    assign gen_inc  = gen_cur + 1'b1;
    assign in_range = (in_w.source < 32'(table_size_reg)) && (in_w.source < 32'(ENTRIES));
    assign gen_ok   = 64'(in_w.expect_gen) <= GEN_MAX;
    assign new_ok   = (64'(in_w.new_artifact) <= ART_MAX) && (64'(in_w.new_slot) <= SLOT_MAX);
    assign exp_ok   = in_w.expected_valid && in_w.expected_bound && gen_ok
                   && (64'(in_w.expected_artifact) <= ART_MAX)
                   && (64'(in_w.expected_slot) <= SLOT_MAX)
                   && ew[BOUND_POS]
                   && (64'(ew[ART_SHIFT +: ART_BITS]) == 64'(in_w.expected_artifact))
                   && (64'(ew[SLOT_BITS-1:0]) == 64'(in_w.expected_slot))
                   && (64'(ew[GEN_SHIFT +: GEN_BITS]) == 64'(in_w.expect_gen));

    always_comb begin
        pre_ok_next  = 1'b0;
        lookup_next  = 1'b0;
        expect_next  = '0;
        desired_next = '0;
        unique case (s_tuser)
            OP_LOOKUP: begin
                lookup_next = in_range;
            end
            OP_RESTORE: begin
                pre_ok_next  = in_range;
                desired_next = ew;
            end
            OP_BIND: begin
                pre_ok_next  = in_range && gen_ok && new_ok;
                expect_next  = word_unbound(gen_cur);
                desired_next = word_bound(in_w.new_artifact[ART_BITS-1:0],
                                          in_w.new_slot[SLOT_BITS-1:0], gen_cur);
            end
            OP_RELEASE: begin
                pre_ok_next  = in_range && exp_ok;
                expect_next  = ew;
                desired_next = word_unbound(gen_inc);
            end
            OP_REBIND: begin
                pre_ok_next  = in_range && exp_ok && new_ok;
                expect_next  = ew;
                desired_next = word_bound(in_w.new_artifact[ART_BITS-1:0],
                                          in_w.new_slot[SLOT_BITS-1:0], gen_inc);
            end
            default: begin
                pre_ok_next = 1'b0;
            end
        endcase
    end

    // compare against the stored entry and build the result
    assign hit = pre_ok_reg && (ram_rdata == expect_reg);

    always_comb begin
        res                  = '0;
        res.success          = hit;
        res.entry_valid      = lookup_reg;
        if (lookup_reg) begin
            res.entry_bound      = ram_rdata[BOUND_POS];
            res.entry_artifact   = 32'(ram_rdata[ART_SHIFT +: ART_BITS]);
            res.entry_slot       = 16'(ram_rdata[SLOT_BITS-1:0]);
            res.entry_generation = 15'(ram_rdata[GEN_SHIFT +: GEN_BITS]);
            res.entry_word       = ram_rdata;
        end
    end

    assign ram_we    = (state_reg == S_CLEAR) || (fire && hit);
    assign ram_waddr = (state_reg == S_CLEAR) ? clr_addr_reg : addr_reg;
    assign ram_wdata = (state_reg == S_CLEAR) ? '0 : desired_reg;

    gtmt_ram #(
        .DEPTH  (ENTRIES),
        .WIDTH  (WORD_W),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk   (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (s_accept),
        .raddr (in_w.source[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_CLEAR;
            clr_addr_reg   <= '0;
            table_size_reg <= TABLE_SIZE_RST;
            m_tvalid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                table_size_reg <= cfg_wr_data;
            end
            if (fire) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR: begin
                    clr_addr_reg <= clr_addr_reg + 1'b1;
                    if (clr_addr_reg == ADDR_W'(ENTRIES - 1)) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_accept) begin
                        addr_reg    <= in_w.source[ADDR_W-1:0];
                        pre_ok_reg  <= pre_ok_next;
                        lookup_reg  <= lookup_next;
                        expect_reg  <= expect_next;
                        desired_reg <= desired_next;
                        state_reg   <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (out_free) begin
                        m_tdata_reg  <= res;
                        state_reg    <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_CLEAR;
                end
            endcase
        end
    end

    `GTMT_ASSERT_NEXT(a_accept_to_exec, s_accept, state_reg == S_EXEC, "accepted word did not start execution")
    `GTMT_ASSERT_IMPL(a_write_not_idle, ram_we, state_reg != S_IDLE, "entry write while idle")
    `GTMT_ASSERT_NEXT(a_fire_loads_out, fire, m_tvalid_reg, "finished word did not reach the output register")
    `GTMT_ASSERT_IMPL(a_lookup_no_success, m_tvalid_reg && m_tdata_reg.entry_valid, !m_tdata_reg.success, "lookup result reports a swap")

endmodule

`default_nettype wire
